/* rtl/core/pnt_pkg.sv */
package pnt_pkg;

  // Width of the number under test.
  localparam int NUMBER_WIDTH = 16;
  // The running sum stays below twice the number, with headroom.
  localparam int SUM_WIDTH    = NUMBER_WIDTH + 2;
  // Step counter of the bit-serial divider: one step per dividend bit.
  localparam int STEP_WIDTH   = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
  // Stream data widths, rounded up to whole bytes.
  localparam int IN_TDATA_WIDTH  = ((NUMBER_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 8;

  typedef logic [NUMBER_WIDTH-1:0] number_t;
  typedef logic [SUM_WIDTH-1:0]    sum_t;
  typedef logic [STEP_WIDTH-1:0]   step_t;

  // Request from the sequencer to the remainder unit.
  typedef struct packed {
    logic    start;
    number_t dividend;
    number_t divisor;
  } div_req_t;

  // Response from the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT,
    ST_CHECK,
    ST_DONE
  } seq_state_t;

endpackage

/* rtl/core/perfect_number_test.sv */
// Perfect number test: one input transaction gives one result transaction.
// Inputs 0 and 1 are answered without the remainder unit; otherwise each
// candidate divisor from 1 to number-1 is tested in turn, with an early
// stop once the divisor sum passes the number.
// Throughput: one number at a time, set by the bit-serial remainder unit.
// Reset: rst_n is synchronous and active low; it returns the block to idle.
module perfect_number_test
  import pnt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  in_tdata,   // [NUMBER_WIDTH-1:0] number
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TDATA_WIDTH-1:0] out_tdata   // [0] is_perfect
);

  seq_state_t state_r, state_nxt;
  number_t    held_r, held_nxt;
  number_t    cand_r, cand_nxt;
  sum_t       sum_r, sum_nxt;
  logic       result_r, result_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_perfect_r, out_perfect_nxt;

  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // The single remainder unit tests one candidate divisor per request.
  pnt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start    = (state_r == ST_TEST);
  assign div_req.dividend = held_r;
  assign div_req.divisor  = cand_r;

  // A new number is taken only when the sequencer is idle. A finished
  // result waits in the output register, so the next transaction can start
  // while the previous answer has not been taken yet.
  assign in_tready = (state_r == ST_IDLE);

  // Sequencer: try each candidate in ascending order, add each divisor to
  // the running sum, and stop once the sum passes the number or the last
  // candidate (number - 1) has been tried.
  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    cand_nxt        = cand_r;
    sum_nxt         = sum_r;
    result_nxt      = result_r;
    out_valid_nxt   = out_valid_r;
    out_perfect_nxt = out_perfect_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          held_nxt = in_tdata[NUMBER_WIDTH-1:0];
          cand_nxt = number_t'(1);
          sum_nxt  = '0;
          // Zero and one are never perfect.
          if (in_tdata[NUMBER_WIDTH-1:1] == '0) begin
            result_nxt = 1'b0;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            sum_nxt = sum_r + {2'b00, cand_r};
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sum_r > {2'b00, held_r}) begin
          // Early stop: the sum can only grow from here.
          result_nxt = 1'b0;
          state_nxt  = ST_DONE;
        end else if (cand_r == held_r - 1'b1) begin
          result_nxt = (sum_r == {2'b00, held_r});
          state_nxt  = ST_DONE;
        end else begin
          cand_nxt  = cand_r + 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_perfect_nxt = result_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r        <= held_nxt;
    cand_r        <= cand_nxt;
    sum_r         <= sum_nxt;
    result_r      <= result_nxt;
    out_perfect_r <= out_perfect_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_WIDTH-1){1'b0}}, out_perfect_r};

  // The remainder unit answers only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_WAIT))
    else $error("divider done outside of wait state");

  // The remainder unit is idle whenever a new number can be taken.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // Candidates never reach the number itself.
  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (cand_r < held_r))
    else $error("candidate divisor out of range");

  // With the early stop the sum stays below twice the number.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sum_r < {1'b0, held_r, 1'b0}))
    else $error("divisor sum out of bound");

  // An accepted transaction always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule

/* rtl/core/pnt_div.sv */
module pnt_div
  import pnt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic    busy_r, busy_nxt;
  logic    done_r, done_nxt;
  step_t   step_r, step_nxt;
  number_t rem_r, rem_nxt;
  number_t dvd_r, dvd_nxt;
  number_t dsr_r, dsr_nxt;

  logic [NUMBER_WIDTH:0] trial;
  logic [NUMBER_WIDTH:0] diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, dvd_r[NUMBER_WIDTH-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = step_t'(NUMBER_WIDTH - 1);
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[NUMBER_WIDTH-1:0];
      end else begin
        rem_nxt = trial[NUMBER_WIDTH-1:0];
      end
      dvd_nxt = {dvd_r[NUMBER_WIDTH-2:0], 1'b0};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule
